### hw/rtl/kct_pkg.sv
`timescale 1ns / 1ps

package kct_pkg;

    // table geometry
    localparam int SLOTS       = 16;
    localparam int KEY_WIDTH   = 8;
    localparam int COUNT_WIDTH = 16;

    // fixed field widths of the ports
    localparam int CMD_W    = 2;
    localparam int IN_KEY_W = 8;
    localparam int AMT_W    = 16;
    localparam int HELD_W   = 16;
    localparam int LIMIT_W  = 5;
    localparam int LIMIT_RESET = 16;

    // derived widths
    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int USED_W  = $clog2(SLOTS + 1);
    localparam int CMP_W   = (USED_W > LIMIT_W) ? USED_W + 1 : LIMIT_W + 1;
    localparam int SUM_W   = ((COUNT_WIDTH > AMT_W) ? COUNT_WIDTH : AMT_W) + 1;
    localparam int ENTRY_W = KEY_WIDTH + COUNT_WIDTH;

    localparam logic [SUM_W-1:0] COUNT_MAX = SUM_W'((64'd1 << COUNT_WIDTH) - 64'd1);

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_MOVE
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [IN_KEY_W-1:0] item_key;
        logic [AMT_W-1:0]    amount;
    } t_item;

    typedef struct packed {
        logic              accepted;
        logic [HELD_W-1:0] held_count;
        logic              changed;
    } t_result;

    // flags and values from the shared compare/add unit
    typedef struct packed {
        logic                   key_match;
        logic                   sum_ovf;
        logic                   cur_ge;
        logic [COUNT_WIDTH-1:0] sum;
        logic [COUNT_WIDTH-1:0] diff;
    } t_alu_res;

endpackage

### hw/rtl/kct_ram.sv
`timescale 1ns / 1ps

module kct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### hw/rtl/kct_alu.sv
`timescale 1ns / 1ps

module kct_alu (
    input  logic [kct_pkg::KEY_WIDTH-1:0]   i_key_a,
    input  logic [kct_pkg::KEY_WIDTH-1:0]   i_key_b,
    input  logic [kct_pkg::COUNT_WIDTH-1:0] i_cur,
    input  logic [kct_pkg::AMT_W-1:0]       i_amt,
    output kct_pkg::t_alu_res               o_res
);

    logic [kct_pkg::SUM_W-1:0] cur_x;
    logic [kct_pkg::SUM_W-1:0] amt_x;
    logic [kct_pkg::SUM_W-1:0] sum_x;
    logic [kct_pkg::SUM_W-1:0] diff_x;

    // widen both operands so carry and borrow are visible
    assign cur_x  = kct_pkg::SUM_W'(i_cur);
    assign amt_x  = kct_pkg::SUM_W'(i_amt);
    assign sum_x  = cur_x + amt_x;
    assign diff_x = cur_x - amt_x;

    assign o_res.key_match = (i_key_a == i_key_b);
    assign o_res.sum_ovf   = (sum_x > kct_pkg::COUNT_MAX);
    assign o_res.cur_ge    = (cur_x >= amt_x);
    assign o_res.sum       = sum_x[kct_pkg::COUNT_WIDTH-1:0];
    assign o_res.diff      = diff_x[kct_pkg::COUNT_WIDTH-1:0];

endmodule

### hw/rtl/keyed_count_table_unit.sv
`timescale 1ns / 1ps

// channel     | direction | handshake               | payload
// ------------+-----------+-------------------------+------------------------------
// command     | in        | i_start, o_busy         | i_item (command, key, amount)
// result      | out       | o_done strobe           | o_result (accepted, count, changed)
// slot limit  | in        | i_cfg_valid, o_cfg_ready| i_cfg_data
//
// A command is taken when i_start is high and o_busy low. The table is scanned
// one slot per cycle through the single read port of the entry memory and the scan
// stops at the matching slot; a removal that moves the last slot into the freed one
// adds a move state after the decision. The result strobe is registered from the
// decision state and rises in the cycle after it; the receiver takes it in that
// cycle and cannot stall.
// Reset clears the slot count and loads the slot limit with 16; entries are
// written before they are ever read, so the memory needs no clearing pass.

module keyed_count_table_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  kct_pkg::t_item              i_item,
    output logic                        o_done,
    output kct_pkg::t_result            o_result,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [kct_pkg::LIMIT_W-1:0] i_cfg_data
);

    localparam int KW = kct_pkg::KEY_WIDTH;
    localparam int CW = kct_pkg::COUNT_WIDTH;
    localparam int IW = kct_pkg::IDX_W;
    localparam int UW = kct_pkg::USED_W;
    localparam int PW = kct_pkg::CMP_W;

    kct_pkg::t_state r_state, n_state;

    logic [kct_pkg::LIMIT_W-1:0] r_limit;
    logic [UW-1:0]               r_used, n_used;
    logic [IW-1:0]               r_idx, n_idx;
    logic [IW-1:0]               r_at, n_at;
    logic                        r_found, n_found;
    logic [CW-1:0]               r_cur, n_cur;
    logic [kct_pkg::CMD_W-1:0]   r_cmd, n_cmd;
    logic [KW-1:0]               r_key, n_key;
    logic [kct_pkg::AMT_W-1:0]   r_amt, n_amt;
    logic                        r_done, n_done;
    kct_pkg::t_result            r_result, n_result;

    logic                        we;
    logic [IW-1:0]               waddr;
    logic [kct_pkg::ENTRY_W-1:0] wdata;
    logic [IW-1:0]               raddr;
    logic [kct_pkg::ENTRY_W-1:0] rdata;
    logic [KW-1:0]               rd_key;
    logic [CW-1:0]               rd_count;
    logic [KW-1:0]               alu_key_b;
    logic [CW-1:0]               alu_cur;
    kct_pkg::t_alu_res           alu;
    logic [PW-1:0]               eff_limit;
    logic [UW-1:0]               last;

    assign rd_key   = rdata[kct_pkg::ENTRY_W-1:CW];
    assign rd_count = rdata[CW-1:0];
    assign last     = r_used - UW'(1);

    // effective limit is the smaller of the register and the table size
    assign eff_limit = (PW'(r_limit) > PW'(kct_pkg::SLOTS)) ? PW'(kct_pkg::SLOTS)
                                                             : PW'(r_limit);

    // entry memory: key in the upper bits, count in the lower
    kct_ram #(
        .WIDTH (kct_pkg::ENTRY_W),
        .DEPTH (kct_pkg::SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // shared compare and add unit: key match while scanning, sums on decision
    assign alu_key_b = rd_key;
    assign alu_cur   = (r_state == kct_pkg::ST_SCAN) ? rd_count : r_cur;

    kct_alu u_alu (
        .i_key_a (r_key),
        .i_key_b (alu_key_b),
        .i_cur   (alu_cur),
        .i_amt   (r_amt),
        .o_res   (alu)
    );

    // state and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kct_pkg::ST_IDLE;
            r_used  <= '0;
            r_done  <= 1'b0;
            r_limit <= kct_pkg::LIMIT_W'(kct_pkg::LIMIT_RESET);
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_done  <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
        end
        r_idx    <= n_idx;
        r_at     <= n_at;
        r_found  <= n_found;
        r_cur    <= n_cur;
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_amt    <= n_amt;
        r_result <= n_result;
    end

    // sequencer: next state, memory access and result
    always_comb begin
        n_state  = r_state;
        n_used   = r_used;
        n_idx    = r_idx;
        n_at     = r_at;
        n_found  = r_found;
        n_cur    = r_cur;
        n_cmd    = r_cmd;
        n_key    = r_key;
        n_amt    = r_amt;
        n_done   = 1'b0;
        n_result = r_result;
        we       = 1'b0;
        waddr    = r_at;
        wdata    = {r_key, alu.sum};
        raddr    = r_idx;

        case (r_state)
            kct_pkg::ST_IDLE: begin
                raddr = '0;
                if (i_start) begin
                    n_cmd   = i_item.command;
                    n_key   = i_item.item_key[KW-1:0];
                    n_amt   = i_item.amount;
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_cur   = '0;
                    n_state = (r_used == '0) ? kct_pkg::ST_DECIDE : kct_pkg::ST_SCAN;
                end
            end

            kct_pkg::ST_SCAN: begin
                // data for slot r_idx is on the read port this cycle
                if (alu.key_match) begin
                    n_found = 1'b1;
                    n_at    = r_idx;
                    n_cur   = rd_count;
                    n_state = kct_pkg::ST_DECIDE;
                end else if ((UW + 1)'(r_idx) + (UW + 1)'(1) >= (UW + 1)'(r_used)) begin
                    n_state = kct_pkg::ST_DECIDE;
                end else begin
                    n_idx = r_idx + IW'(1);
                    raddr = r_idx + IW'(1);
                end
            end

            kct_pkg::ST_DECIDE: begin
                n_done  = 1'b1;
                n_state = kct_pkg::ST_IDLE;
                n_result.accepted   = 1'b0;
                n_result.held_count = kct_pkg::HELD_W'(r_cur);
                n_result.changed    = 1'b0;
                raddr = last[IW-1:0];

                if (r_cmd == kct_pkg::CMD_ADD) begin
                    // sum overflow also covers a new key with too large an amount
                    if (r_key != '0 && r_amt != '0 && !alu.sum_ovf) begin
                        if (r_found) begin
                            we    = 1'b1;
                            waddr = r_at;
                            wdata = {r_key, alu.sum};
                            n_result.accepted   = 1'b1;
                            n_result.held_count = kct_pkg::HELD_W'(alu.sum);
                            n_result.changed    = 1'b1;
                        end else if (PW'(r_used) < eff_limit) begin
                            we     = 1'b1;
                            waddr  = r_used[IW-1:0];
                            wdata  = {r_key, alu.sum};
                            n_used = r_used + UW'(1);
                            n_result.accepted   = 1'b1;
                            n_result.held_count = kct_pkg::HELD_W'(alu.sum);
                            n_result.changed    = 1'b1;
                        end
                    end
                end else if (r_cmd == kct_pkg::CMD_REMOVE) begin
                    if (r_key != '0 && r_amt != '0 && r_found && alu.cur_ge) begin
                        n_result.accepted   = 1'b1;
                        n_result.held_count = kct_pkg::HELD_W'(alu.diff);
                        n_result.changed    = 1'b1;
                        if (alu.diff == '0) begin
                            // free the slot; the last slot moves into the gap
                            n_used = last;
                            if (UW'(r_at) != last) begin
                                n_state = kct_pkg::ST_MOVE;
                            end
                        end else begin
                            we    = 1'b1;
                            waddr = r_at;
                            wdata = {r_key, alu.diff};
                        end
                    end
                end else begin
                    // query, and the unused code handled alike
                    n_result.accepted = alu.cur_ge;
                end
            end

            kct_pkg::ST_MOVE: begin
                we      = 1'b1;
                waddr   = r_at;
                wdata   = rdata;
                n_state = kct_pkg::ST_IDLE;
            end

            default: begin
                n_state = kct_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy      = (r_state != kct_pkg::ST_IDLE);
    assign o_cfg_ready = (r_state == kct_pkg::ST_IDLE);
    assign o_done      = r_done;
    assign o_result    = r_result;

endmodule
